// File: rtl/lif_pkg.sv
// shared types and constants for the spiking layer
package lif_pkg;
  localparam int KIND_W  = 3;
  localparam int IDX_W   = 6;
  localparam int VOLT_W  = 16;
  localparam int LEAK_W  = 16;
  localparam int END_W   = 7;

  localparam logic [KIND_W-1:0] KIND_LOAD_W = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SPIKE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;

  localparam logic [1:0] REG_LEAK  = 2'd0;
  localparam logic [1:0] REG_THR   = 2'd1;
  localparam logic [1:0] REG_FIRST = 2'd2;
  localparam logic [1:0] REG_END   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  input_index;
    logic [IDX_W-1:0]  neuron_index;
    logic signed [VOLT_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] fired_neuron;
    logic             fired;
    logic             last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic [KIND_W-1:0] kind;
    logic             sweep;
    logic [IDX_W-1:0] n;
    logic             clr_all;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             wb_valid;
    logic             wb_fire;
    logic [IDX_W-1:0] wb_n;
  } dp_stat_t;
endpackage

// File: rtl/lif_if.sv
// valid/ready channel interfaces
interface lif_in_if;
  import lif_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lif_out_if;
  import lif_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/lif_datapath.sv
// weight, bias and membrane stores with the neuron update pipeline
module lif_datapath #(
  parameter int NUM_INPUTS  = 64,
  parameter int NUM_OUTPUTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lif_pkg::dp_cmd_t              cmd,
  input  lif_pkg::in_word_t             item,
  input  logic [lif_pkg::LEAK_W-1:0]    leak,
  input  logic signed [lif_pkg::VOLT_W-1:0] thr,
  output lif_pkg::dp_stat_t             stat
);
  import lif_pkg::*;
  localparam int IN_W  = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int OUT_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int WDEPTH = NUM_INPUTS * NUM_OUTPUTS;
  localparam int WA_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

  logic signed [VOLT_W-1:0] wmem [WDEPTH];
  logic signed [VOLT_W-1:0] bmem [NUM_OUTPUTS];
  logic signed [VOLT_W-1:0] mem_r [NUM_OUTPUTS];
  // membrane entries written since the last clear, others read as zero
  logic [NUM_OUTPUTS-1:0]   mvld_r;

  logic [KIND_W-1:0]        kind_r;
  logic [IN_W-1:0]          row_r;
  logic                     s1_v_r, s2_v_r;
  logic [IDX_W-1:0]         s1_n_r, s2_n_r;
  logic signed [VOLT_W-1:0] w_rd_r, b_rd_r, m1_r;
  logic signed [VOLT_W+LEAK_W+1:0] prod_r;
  logic signed [VOLT_W-1:0] m2_r, w2_r, b2_r;
  logic [KIND_W-1:0]        k2_r;
  logic                     wb_en;

  logic [WA_W-1:0] wr_addr, rd_addr;
  logic [OUT_W-1:0] ncol;

  assign ncol    = OUT_W'(item.neuron_index);
  assign wr_addr = WA_W'(WA_W'(item.input_index) * WA_W'(NUM_OUTPUTS) + WA_W'(ncol));
  assign rd_addr = WA_W'(WA_W'(row_r) * WA_W'(NUM_OUTPUTS) + WA_W'(cmd.n[OUT_W-1:0]));
  assign wb_en   = s2_v_r && (k2_r == KIND_START || k2_r == KIND_SPIKE);

  always_ff @(posedge clk) begin
    if (cmd.load && item.kind == KIND_LOAD_W &&
        32'(item.input_index) < NUM_INPUTS && 32'(item.neuron_index) < NUM_OUTPUTS)
      wmem[wr_addr] <= item.value;
    if (cmd.load && item.kind == KIND_LOAD_B && 32'(item.neuron_index) < NUM_OUTPUTS)
      bmem[ncol] <= item.value;
    w_rd_r <= wmem[rd_addr];
    b_rd_r <= bmem[cmd.n[OUT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_LOAD_W;
      row_r  <= '0;
    end else if (cmd.load) begin
      kind_r <= item.kind;
      row_r  <= IN_W'(item.input_index);
    end
  end

  // stage 1: stores read, stage 2: product, stage 3: writeback
  logic signed [VOLT_W+LEAK_W+1:0] scaled_full, upd;
  logic signed [VOLT_W:0] acc;
  logic signed [VOLT_W-1:0] wb_val;

  always_comb begin
    scaled_full = (prod_r + (VOLT_W+LEAK_W+2)'(16384)) >>> 15;
    upd = scaled_full + (VOLT_W+LEAK_W+2)'(b2_r);
    if (m2_r > thr) upd = upd - (VOLT_W+LEAK_W+2)'(thr);
    acc = (VOLT_W+1)'(m2_r) + (VOLT_W+1)'(w2_r);
    wb_val = m2_r;
    unique case (k2_r)
      KIND_START: begin
        if (upd > 32767) wb_val = 16'sh7fff;
        else if (upd < -32768) wb_val = 16'sh8000;
        else wb_val = upd[VOLT_W-1:0];
      end
      KIND_SPIKE: begin
        if (acc > 32767) wb_val = 16'sh7fff;
        else if (acc < -32768) wb_val = 16'sh8000;
        else wb_val = acc[VOLT_W-1:0];
      end
      default: wb_val = m2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    m1_r   <= mvld_r[cmd.n[OUT_W-1:0]] ? mem_r[cmd.n[OUT_W-1:0]] : '0;
    s1_n_r <= cmd.n;
    prod_r <= (VOLT_W+LEAK_W+2)'(m1_r) * $signed({2'b0, leak});
    m2_r   <= m1_r;
    w2_r   <= w_rd_r;
    b2_r   <= b_rd_r;
    k2_r   <= kind_r;
    s2_n_r <= s1_n_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.sweep;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_all) begin
      mvld_r <= '0;
    end else if (wb_en) begin
      mvld_r[s2_n_r[OUT_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) mem_r[s2_n_r[OUT_W-1:0]] <= wb_val;
  end

  assign stat.wb_valid = s2_v_r;
  assign stat.wb_fire  = s2_v_r && (k2_r == KIND_END) && (m2_r > thr);
  assign stat.wb_n     = s2_n_r;
endmodule

// File: rtl/lif_ctrl.sv
// item sequencer and result buffer
module lif_ctrl #(
  parameter int NUM_INPUTS  = 64,
  parameter int NUM_OUTPUTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  lif_in_if.sink                     in_ch,
  lif_out_if.source                  out_ch,
  input  logic [lif_pkg::IDX_W-1:0]  first_n,
  input  logic [lif_pkg::END_W-1:0]  end_n,
  output lif_pkg::dp_cmd_t           cmd,
  input  lif_pkg::dp_stat_t          stat
);
  import lif_pkg::*;
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;
  localparam int FIFO_D = 4;

  logic [1:0]       state_r, state_nxt;
  logic [END_W-1:0] n_r, n_nxt, hi;
  logic [1:0]       dr_r, dr_nxt;
  logic [KIND_W-1:0] kind_r;
  logic             sweep_end;
  // one-deep hold of a fired index, so last can be marked on the final one
  logic             pend_r, any_r;
  logic [IDX_W-1:0] pend_n_r;
  // result words waiting for the sink, room for those still in the pipeline
  out_word_t        fifo_r [FIFO_D];
  logic [1:0]       wp_r, rp_r;
  logic [2:0]       cnt_r;
  logic             push, pop;
  out_word_t        push_w;
  logic             accept, stall;

  assign hi = (32'(end_n) > NUM_OUTPUTS) ? END_W'(NUM_OUTPUTS) : end_n;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign stall = (cnt_r >= 3'd2);
  assign out_ch.valid = (cnt_r != 3'd0);
  assign out_ch.data  = fifo_r[rp_r];
  assign pop = out_ch.valid && out_ch.ready;

  assign cmd.load    = accept;
  assign cmd.kind    = in_ch.data.kind;
  assign cmd.sweep   = (state_r == ST_SWEEP) && !stall;
  assign cmd.n       = n_r[IDX_W-1:0];
  assign cmd.clr_all = accept && in_ch.data.kind == KIND_CLEAR;

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r;
    dr_nxt = dr_r;
    unique case (state_r)
      ST_IDLE: if (accept) begin
        n_nxt = END_W'(first_n);
        if (in_ch.data.kind == KIND_START || in_ch.data.kind == KIND_END ||
            (in_ch.data.kind == KIND_SPIKE && 32'(in_ch.data.input_index) < NUM_INPUTS)) begin
          state_nxt = (END_W'(first_n) < hi) ? ST_SWEEP : ST_DRAIN;
        end
        dr_nxt = 2'd2;
      end
      ST_SWEEP: if (!stall) begin
        n_nxt = n_r + END_W'(1);
        if (n_nxt >= hi) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: if (!stall) begin
        if (dr_r == 2'd0) state_nxt = (kind_r == KIND_END) ? ST_FLUSH : ST_IDLE;
        else dr_nxt = dr_r - 2'd1;
      end
      default: if (!stall) state_nxt = ST_IDLE;
    endcase
  end

  assign sweep_end = (state_r == ST_FLUSH) && !stall;

  always_comb begin
    push = 1'b0;
    push_w = '{fired_neuron: pend_n_r, fired: 1'b1, last: 1'b0};
    if (stat.wb_fire) begin
      push = pend_r;
    end else if (sweep_end) begin
      push = 1'b1;
      if (any_r) push_w.last = 1'b1;
      else push_w = '{fired_neuron: '0, fired: 1'b0, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      n_r <= '0;
      dr_r <= '0;
      kind_r <= KIND_LOAD_W;
      pend_r <= 1'b0;
      any_r <= 1'b0;
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      n_r <= n_nxt;
      dr_r <= dr_nxt;
      if (accept) begin
        kind_r <= in_ch.data.kind;
        any_r <= 1'b0;
      end else if (stat.wb_fire) begin
        any_r <= 1'b1;
      end
      if (stat.wb_fire) begin
        pend_r <= 1'b1;
        pend_n_r <= stat.wb_n;
      end else if (sweep_end) begin
        pend_r <= 1'b0;
      end
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= push_w;
  end
endmodule

// File: rtl/lif_spiking_linear_layer.sv
// spiking LIF layer top level: register file, controller and datapath
// loads and clear take effect on acceptance; start, spike and end sweep the neurons in the
//   active range, one membrane per cycle while the sweep is not stalled; end adds a flush
// one item at a time, no new item until the last one is through; the sweep holds while two or more words wait
// fired words leave one per cycle while the sink is ready, through a four-word buffer
// reset: synchronous active low, membranes zero, registers to defaults, stores undefined
module lif_spiking_linear_layer #(
  parameter int NUM_INPUTS  = 64,
  parameter int NUM_OUTPUTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  lif_in_if.sink      in_ch,
  lif_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lif_pkg::*;

  logic [LEAK_W-1:0]        leak_r;
  logic signed [VOLT_W-1:0] thr_r;
  logic [IDX_W-1:0]         first_r;
  logic [END_W-1:0]         end_r;
  logic                     wr;
  dp_cmd_t                  cmd;
  dp_stat_t                 stat;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leak_r  <= 16'd29491;
      thr_r   <= 16'sd1024;
      first_r <= '0;
      end_r   <= 7'd64;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      unique case (cfg_paddr[3:2])
        REG_LEAK:  leak_r  <= cfg_pwdata[LEAK_W-1:0];
        REG_THR:   thr_r   <= cfg_pwdata[VOLT_W-1:0];
        REG_FIRST: first_r <= cfg_pwdata[IDX_W-1:0];
        default:   end_r   <= cfg_pwdata[END_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_LEAK:  cfg_prdata = 32'(leak_r);
      REG_THR:   cfg_prdata = 32'(unsigned'(thr_r));
      REG_FIRST: cfg_prdata = 32'(first_r);
      default:   cfg_prdata = 32'(end_r);
    endcase
  end

  lif_ctrl #(.NUM_INPUTS(NUM_INPUTS), .NUM_OUTPUTS(NUM_OUTPUTS)) u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch, .first_n(first_r), .end_n(end_r), .cmd, .stat
  );

  lif_datapath #(.NUM_INPUTS(NUM_INPUTS), .NUM_OUTPUTS(NUM_OUTPUTS)) u_dp (
    .clk, .rst_n, .cmd, .item(in_ch.data), .leak(leak_r), .thr(thr_r), .stat
  );

  a_no_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !stat.wb_fire) else $error("fire while idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data.fired |-> out_ch.data.last) else $error("bad marker");
endmodule
